FILE: design/rfnd_pkg.sv
package rfnd_pkg;

    localparam int NameLength = 8;
    localparam int CharWidth  = 8;
    localparam int NameWidth  = NameLength * CharWidth;
    localparam int FreqWidth  = 19;
    localparam int ChanWidth  = 10;
    localparam int StepWidth  = 8;
    localparam int BaseWidth  = 17;
    localparam int OutWidth   = 104;

    localparam logic [CharWidth-1:0] CharSpace = 8'h20;

    localparam logic [1:0] CfgBandSelect    = 2'd0;
    localparam logic [1:0] CfgSpacingSelect = 2'd1;

    localparam logic OpSnapshot  = 1'b0;
    localparam logic OpTuneStart = 1'b1;

    // name update request from the status decode to the name store
    typedef struct packed {
        logic        tune_start;
        logic        take;
        logic [1:0]  segment;
        logic [15:0] text;
    } name_req_t;

    function automatic logic [BaseWidth-1:0] band_base(input logic [1:0] band);
        logic [BaseWidth-1:0] base;
        unique case (band)
            2'd0:    base = 17'd87000;
            2'd1:    base = 17'd76000;
            2'd2:    base = 17'd76000;
            default: base = 17'd65000;
        endcase
        return base;
    endfunction

    function automatic logic [StepWidth-1:0] chan_step(input logic [1:0] spacing);
        logic [StepWidth-1:0] step;
        unique case (spacing)
            2'd0:    step = 8'd100;
            2'd1:    step = 8'd200;
            2'd2:    step = 8'd50;
            default: step = 8'd25;
        endcase
        return step;
    endfunction

endpackage

FILE: design/fm_tuner_status_rds_name_decoder_core.sv
// FM tuner status and RDS program service name decoder.
//
// Input channel s_*: one item per status snapshot or tune/seek start event.
// s_tuser carries the opcode, s_tdata the four status and RDS words.
// Output channel m_*: one result item per input item, in order.
// Configuration channel cfg_*: band and channel spacing registers, always
// ready; write them only while no item is in flight.
//
// An item is captured in an input register, decoded in one pass (a small
// constant-step multiply for the frequency and per-entry name compares)
// and stored in the output register, from which the result is offered on m_*.
// One item per cycle is sustained while the receiver keeps m_tready high.
// When the receiver stalls, the output register holds its result and the
// input register takes one more item; then s_tready drops until m_tready.
// Reset empties both registers, clears the tuning flag, held error count
// and candidate characters, and sets the name to eight spaces.
module fm_tuner_status_rds_name_decoder_core
    import rfnd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // opcode
    input  logic [0:0]          s_tuser,
    // status_word_a, status_word_b, rds_group_word, rds_text_word
    input  logic [63:0]         s_tdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    // rds_ready, still_tuning, seek_failed, block_e_present, is_stereo,
    // frequency_khz, signal_strength, on_station, rds_errors, name_valid,
    // station_name, actions, one zero pad bit
    output logic [OutWidth-1:0] m_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [1:0]          cfg_data
);

    logic        in_valid_reg;
    logic        in_op_reg;
    logic [15:0] in_a_reg;
    logic [15:0] in_b_reg;
    logic [15:0] in_grp_reg;
    logic [15:0] in_txt_reg;

    logic                out_valid_reg;
    logic [OutWidth-1:0] out_data_reg;
    logic [OutWidth-1:0] out_data_next;

    logic [1:0] band_reg;
    logic [1:0] spacing_reg;
    logic       tuning_reg;
    logic       tuning_next;
    logic [3:0] errors_reg;
    logic [3:0] errors_next;

    logic advance;

    logic                 rdy;
    logic                 done;
    logic [FreqWidth-1:0] freq;
    logic [NameWidth-1:0] name_next;
    logic                 seen_next;
    logic [1:0]           act;
    name_req_t            req;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign rdy  = in_a_reg[15];
    assign done = in_a_reg[14];

    rfnd_freq u_freq (
        .band_select    (band_reg),
        .spacing_select (spacing_reg),
        .channel        (in_a_reg[ChanWidth-1:0]),
        .frequency_khz  (freq)
    );

    always_comb
    begin
        req.tune_start = (in_op_reg == OpTuneStart);
        req.take       = (in_op_reg == OpSnapshot) && rdy && !in_b_reg[4]
                       && (in_grp_reg[15:12] == 4'd0);
        req.segment    = in_grp_reg[1:0];
        req.text       = in_txt_reg;
    end

    rfnd_name u_name (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .req       (req),
        .name_next (name_next),
        .seen_next (seen_next)
    );

    always_comb
    begin
        errors_next   = errors_reg;
        tuning_next   = tuning_reg;
        act           = 2'b00;
        out_data_next = '0;
        if (in_op_reg == OpTuneStart)
        begin
            tuning_next           = 1'b1;
            out_data_next[1]      = 1'b1;
            out_data_next[35:32]  = errors_reg;
            out_data_next[100:37] = name_next;
        end
        else
        begin
            tuning_next = !done;
            if (rdy)
            begin
                errors_next = in_b_reg[3:0];
            end
            act[0] = rdy;
            act[1] = tuning_reg && done;
            out_data_next[0]      = rdy;
            out_data_next[1]      = !done;
            out_data_next[2]      = in_a_reg[13];
            out_data_next[3]      = in_a_reg[11];
            out_data_next[4]      = in_a_reg[10];
            out_data_next[23:5]   = freq;
            out_data_next[30:24]  = in_b_reg[15:9];
            out_data_next[31]     = in_b_reg[8];
            out_data_next[35:32]  = errors_next;
            out_data_next[36]     = seen_next;
            out_data_next[100:37] = name_next;
            out_data_next[102:101] = act;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_reg    <= 2'd0;
            spacing_reg <= 2'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CfgBandSelect:    band_reg    <= cfg_data;
                CfgSpacingSelect: spacing_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // payload of the input register, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg  <= s_tuser[0];
            in_a_reg   <= s_tdata[15:0];
            in_b_reg   <= s_tdata[31:16];
            in_grp_reg <= s_tdata[47:32];
            in_txt_reg <= s_tdata[63:48];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            tuning_reg    <= 1'b0;
            errors_reg    <= 4'd0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                tuning_reg    <= tuning_next;
                errors_reg    <= errors_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // a full input stage behind a stalled result must not take an item
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while both stages are blocked");

    // a tune start reports tuning and an unconfirmed name
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_op_reg == OpTuneStart) |=>
            (m_tdata[1] && !m_tdata[36] && m_tdata[102:101] == 2'b00))
        else $error("tune start result carries stale flags");

    // stop tune only goes out with tune complete
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[102]) |-> !m_tdata[1])
        else $error("stop tune without tune complete");

    // reported error count tracks the held count
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[35:32] == errors_reg))
        else $error("reported error count differs from held count");

endmodule

FILE: design/rfnd_freq.sv
module rfnd_freq
    import rfnd_pkg::*;
(
    input  logic [1:0]           band_select,
    input  logic [1:0]           spacing_select,
    input  logic [ChanWidth-1:0] channel,
    output logic [FreqWidth-1:0] frequency_khz
);

    logic [ChanWidth+StepWidth-1:0] offset;

    assign offset = channel * chan_step(spacing_select);

    assign frequency_khz = FreqWidth'(band_base(band_select))
                         + FreqWidth'(offset);

endmodule

FILE: design/rfnd_name.sv
module rfnd_name
    import rfnd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  name_req_t            req,
    output logic [NameWidth-1:0] name_next,
    output logic                 seen_next
);

    logic [CharWidth-1:0] cand_reg [NameLength];
    logic [CharWidth-1:0] cand_next [NameLength];
    logic [CharWidth-1:0] conf_reg [NameLength];
    logic [CharWidth-1:0] conf_next [NameLength];
    logic                 seen_reg;

    // each entry compares against the character that would land on it
    always_comb
    begin
        logic [CharWidth-1:0] ch;
        logic                 hit;
        logic                 any_confirm;
        any_confirm = 1'b0;
        for (int i = 0; i < NameLength; i++)
        begin
            ch  = (i % 2 == 0) ? req.text[15:8] : req.text[7:0];
            hit = req.take && (req.segment == 2'(i / 2));
            cand_next[i] = cand_reg[i];
            conf_next[i] = conf_reg[i];
            if (req.tune_start)
            begin
                conf_next[i] = CharSpace;
            end
            else if (hit)
            begin
                if (cand_reg[i] == ch)
                begin
                    conf_next[i] = ch;
                    any_confirm  = 1'b1;
                end
                else
                begin
                    cand_next[i] = ch;
                end
            end
        end
        if (req.tune_start)
        begin
            seen_next = 1'b0;
        end
        else
        begin
            seen_next = seen_reg | any_confirm;
        end
    end

    // character 0 goes to the top byte
    always_comb
    begin
        for (int i = 0; i < NameLength; i++)
        begin
            name_next[NameWidth-1-i*CharWidth -: CharWidth] = conf_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
            for (int i = 0; i < NameLength; i++)
            begin
                cand_reg[i] <= '0;
                conf_reg[i] <= CharSpace;
            end
        end
        else if (en)
        begin
            seen_reg <= seen_next;
            for (int i = 0; i < NameLength; i++)
            begin
                cand_reg[i] <= cand_next[i];
                conf_reg[i] <= conf_next[i];
            end
        end
    end

endmodule

FILE: bench/fm_tuner_status_rds_name_decoder_core_test.sv
`timescale 1ns / 1ps

module fm_tuner_status_rds_name_decoder_core_test;
    import rfnd_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int HoldAfter  = 400;
    localparam int HoldCycles = 250;
    localparam int PhaseItems = 216;

    typedef struct {
        logic        op;
        logic [15:0] word_a;
        logic [15:0] word_b;
        logic [15:0] group_word;
        logic [15:0] text_word;
    } status_item_t;

    // laid out from the top bit down so that it matches m_tdata
    typedef struct packed {
        logic                 pad;
        logic [1:0]           actions;
        logic [NameWidth-1:0] name;
        logic                 name_valid;
        logic [3:0]           rds_err;
        logic                 on_station;
        logic [6:0]           rssi;
        logic [FreqWidth-1:0] freq;
        logic                 stereo;
        logic                 block_e;
        logic                 seek_failed;
        logic                 still_tuning;
        logic                 rds_ready;
    } decoded_status_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic [0:0]          s_tuser = '0;
    logic [63:0]         s_tdata = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [OutWidth-1:0] m_tdata;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_index = '0;
    logic [1:0]          cfg_data = '0;

    fm_tuner_status_rds_name_decoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    status_item_t    pending_items[$];
    decoded_status_t expected_status[$];

    logic steady = 1'b0;
    int   cycles = 0;
    int   mismatches = 0;
    int   items_taken = 0;
    int   results_checked = 0;
    int   settings_used = 1;

    // predictor copy of the block
    logic [1:0] band = 2'd0;
    logic [1:0] spacing = 2'd0;
    logic       tune_pending = 1'b0;
    logic [7:0] cand_chars [NameLength] = '{default: 8'h00};
    logic [7:0] name_chars [NameLength] = '{default: CharSpace};
    logic       name_seen_r = 1'b0;
    logic [3:0] held_err = 4'd0;
    int         tune_starts = 0;
    int         chars_confirmed = 0;

    // receiver side
    int         results_taken = 0;
    int         hold_left = 0;
    logic       hold_done = 1'b0;

    logic [15:0] station_words [4];

    function automatic logic [NameWidth-1:0] packed_name();
        logic [NameWidth-1:0] v;
        v = '0;
        for (int i = 0; i < NameLength; i++)
            v = {v[NameWidth-9:0], name_chars[i]};
        return v;
    endfunction

    function automatic void offer_char(int pos, logic [7:0] c);
        if (cand_chars[pos] == c)
        begin
            name_chars[pos] = c;
            name_seen_r = 1'b1;
            chars_confirmed++;
        end
        else
            cand_chars[pos] = c;
    endfunction

    function automatic decoded_status_t decode_item(status_item_t it);
        decoded_status_t r;
        logic            rdy;
        logic            done;
        int              seg;
        int              base_khz;
        int              step_khz;
        r = '0;
        if (it.op == OpTuneStart)
        begin
            tune_pending = 1'b1;
            for (int i = 0; i < NameLength; i++)
                name_chars[i] = CharSpace;
            name_seen_r = 1'b0;
            tune_starts++;
            r.still_tuning = 1'b1;
            r.rds_err = held_err;
            r.name = packed_name();
            return r;
        end
        rdy = it.word_a[15];
        done = it.word_a[14];
        r.actions = {tune_pending & done, rdy};
        tune_pending = ~done;
        if (rdy)
        begin
            held_err = it.word_b[3:0];
            // groups 0A and 0B only, and never on a block E capture
            if (!it.word_b[4] && it.group_word[15:12] == 4'd0)
            begin
                seg = it.group_word[1:0];
                offer_char(2 * seg, it.text_word[15:8]);
                offer_char(2 * seg + 1, it.text_word[7:0]);
            end
        end
        case (band)
            2'd0:    base_khz = 87000;
            2'd3:    base_khz = 65000;
            default: base_khz = 76000;
        endcase
        case (spacing)
            2'd0:    step_khz = 100;
            2'd1:    step_khz = 200;
            2'd2:    step_khz = 50;
            default: step_khz = 25;
        endcase
        r.rds_ready = rdy;
        r.still_tuning = ~done;
        r.seek_failed = it.word_a[13];
        r.block_e = it.word_a[11];
        r.stereo = it.word_a[10];
        r.freq = FreqWidth'(base_khz + int'(it.word_a[9:0]) * step_khz);
        r.rssi = it.word_b[15:9];
        r.on_station = it.word_b[8];
        r.rds_err = held_err;
        r.name_valid = name_seen_r;
        r.name = packed_name();
        return r;
    endfunction

    function automatic void check_field(string label, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h actual %h", $time, label, want, got);
            mismatches++;
        end
    endfunction

    function automatic status_item_t mk(logic op, logic [15:0] a, logic [15:0] b,
                                        logic [15:0] grp, logic [15:0] txt);
        status_item_t it;
        it.op = op;
        it.word_a = a;
        it.word_b = b;
        it.group_word = grp;
        it.text_word = txt;
        return it;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tuser <= '0;
            s_tdata <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (pending_items.size() > 0 && (steady || $urandom_range(0, 99) >= 16))
            begin
                s_tvalid <= 1'b1;
                s_tuser <= pending_items[0].op;
                s_tdata <= {pending_items[0].text_word, pending_items[0].group_word,
                            pending_items[0].word_b, pending_items[0].word_a};
                void'(pending_items.pop_front());
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver, with one long hold-off to back the block up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                results_taken++;
            if (!hold_done && results_taken >= HoldAfter)
            begin
                hold_done = 1'b1;
                hold_left = HoldCycles;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= steady || ($urandom_range(0, 99) >= 16);
        end
    end

    // predict on input accept, check on output accept
    always @(posedge clk)
    begin
        decoded_status_t want;
        decoded_status_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CfgBandSelect:    band = cfg_data;
                    CfgSpacingSelect: spacing = cfg_data;
                    default:          ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got = decoded_status_t'(m_tdata);
                if (expected_status.size() == 0)
                begin
                    $display("%0t: unexpected result expected none actual %h", $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_status.pop_front();
                    results_checked++;
                    check_field("rds_ready", want.rds_ready, got.rds_ready);
                    check_field("still_tuning", want.still_tuning, got.still_tuning);
                    check_field("seek_failed", want.seek_failed, got.seek_failed);
                    check_field("block_e_present", want.block_e, got.block_e);
                    check_field("is_stereo", want.stereo, got.stereo);
                    check_field("frequency_khz", want.freq, got.freq);
                    check_field("signal_strength", want.rssi, got.rssi);
                    check_field("on_station", want.on_station, got.on_station);
                    check_field("rds_errors", want.rds_err, got.rds_err);
                    check_field("name_valid", want.name_valid, got.name_valid);
                    check_field("station_name", want.name, got.name);
                    check_field("actions", want.actions, got.actions);
                end
            end
            if (s_tvalid && s_tready)
            begin
                items_taken++;
                expected_status.push_back(decode_item(mk(s_tuser[0], s_tdata[15:0],
                    s_tdata[31:16], s_tdata[47:32], s_tdata[63:48])));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || s_tvalid || expected_status.size() != 0)
            @(posedge clk);
        // drain the pipeline before touching the registers
        repeat (4) @(posedge clk);
    endtask

    task automatic new_station();
        for (int i = 0; i < 4; i++)
            station_words[i] = 16'($urandom);
    endtask

    task automatic queue_random(int count);
        int          n;
        int          r;
        int          seg;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] grp;
        n = 0;
        while (n < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
            begin
                pending_items.push_back(mk(OpTuneStart, 16'($urandom), 16'($urandom),
                                           16'($urandom), 16'($urandom)));
                new_station();
                n++;
            end
            else if (r < 75)
            begin
                // well-formed group 0A/0B segment, usually repeated to confirm
                seg = $urandom_range(0, 3);
                a = {1'b1, 15'($urandom)};
                b = 16'($urandom) & 16'hFFEF;
                grp = {4'b0000, 1'($urandom), 9'($urandom), 2'(seg)};
                pending_items.push_back(mk(OpSnapshot, a, b, grp, station_words[seg]));
                n++;
                if ($urandom_range(0, 4) != 0)
                begin
                    a = {1'b1, 15'($urandom)};
                    pending_items.push_back(mk(OpSnapshot, a, b, grp, station_words[seg]));
                    n++;
                end
            end
            else if (r < 90)
            begin
                pending_items.push_back(mk(OpSnapshot, 16'($urandom), 16'($urandom),
                                           16'($urandom), 16'($urandom)));
                n++;
            end
            else
            begin
                // no RDS data, or a block E capture
                a = 16'($urandom);
                b = 16'($urandom) | 16'h0010;
                pending_items.push_back(mk(OpSnapshot, a, b, 16'($urandom) & 16'h07FF,
                                           16'($urandom)));
                n++;
            end
        end
    endtask

    initial
    begin
        logic [1:0] bands [5];
        logic [1:0] spacings [5];
        bands = '{2'd3, 2'd1, 2'd2, 2'd0, 2'd0};
        spacings = '{2'd3, 2'd2, 2'd0, 2'd3, 2'd1};
        new_station();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed items, reset configuration
        pending_items.push_back(mk(OpSnapshot, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        // zero characters match the cleared candidates at once
        pending_items.push_back(mk(OpSnapshot, 16'h8000, 16'h0000, 16'h0000, 16'h0000));
        pending_items.push_back(mk(OpTuneStart, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        pending_items.push_back(mk(OpSnapshot, 16'h0000, 16'hFF00, 16'h0000, 16'h0000));
        // tune completes while tuning: stop action
        pending_items.push_back(mk(OpSnapshot, 16'h7FFF, 16'h0100, 16'h0000, 16'h0000));
        pending_items.push_back(mk(OpSnapshot, 16'h8000, 16'h000F, 16'h0000, 16'h5052));
        pending_items.push_back(mk(OpSnapshot, 16'h8000, 16'h000F, 16'h0000, 16'h5052));
        pending_items.push_back(mk(OpSnapshot, 16'hC3FF, 16'h0003, 16'h0FFF, 16'hFF41));
        pending_items.push_back(mk(OpSnapshot, 16'hC3FF, 16'h0003, 16'h0FFF, 16'hFF41));
        // other group leaves the name alone
        pending_items.push_back(mk(OpSnapshot, 16'h8000, 16'h0000, 16'h1001, 16'h4142));
        pending_items.push_back(mk(OpSnapshot, 16'h8000, 16'h0000, 16'h1001, 16'h4142));
        // block E capture: errors taken, no characters
        pending_items.push_back(mk(OpSnapshot, 16'h8000, 16'h0015, 16'h0001, 16'h4344));
        pending_items.push_back(mk(OpSnapshot, 16'h8000, 16'h0015, 16'h0001, 16'h4344));
        // no RDS data: errors held
        pending_items.push_back(mk(OpSnapshot, 16'h0400, 16'h000A, 16'h0002, 16'h4546));
        pending_items.push_back(mk(OpSnapshot, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        pending_items.push_back(mk(OpSnapshot, 16'hFFFF, 16'hFFEF, 16'h07FF, 16'hFFFF));
        pending_items.push_back(mk(OpSnapshot, 16'hFFFF, 16'hFFEF, 16'h07FF, 16'hFFFF));
        pending_items.push_back(mk(OpTuneStart, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        pending_items.push_back(mk(OpSnapshot, 16'h8000, 16'h0000, 16'h0002, 16'h2020));
        pending_items.push_back(mk(OpSnapshot, 16'hC000, 16'h0000, 16'h0002, 16'h2020));
        pending_items.push_back(mk(OpSnapshot, 16'h4001, 16'h0000, 16'h0000, 16'h0000));

        for (int p = 0; p < 5; p++)
        begin
            wait_idle();
            write_reg(CfgBandSelect, bands[p]);
            write_reg(CfgSpacingSelect, spacings[p]);
            cfg_valid <= 1'b0;
            settings_used++;
            steady = (p == 3);
            queue_random(PhaseItems);
        end

        wait_idle();
        repeat (6) @(posedge clk);
        $display("checked %0d results from %0d items over %0d band and spacing settings",
                 results_checked, items_taken, settings_used);
        $display("%0d tune starts, %0d name characters confirmed, %0d mismatches",
                 tune_starts, chars_confirmed, mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
